// File: hdl/radvig_pkg.sv
// Shared types, constants and helpers for the radial vignette gain block.
package radvig_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int OFS_W      = 13;
    localparam int OFS_SQ_W   = 26;
    localparam int NUM_W      = 44;
    localparam int DEN_W      = 42;
    localparam int Q_W        = 18;
    localparam int SQ_W       = 19;
    localparam int DIV_STAGES = 18;
    localparam int GAIN_W     = 17;

    localparam logic [15:0]     RATIO_SCALE = 16'd40000;
    localparam logic [11:0]     QUARTIC_Q16 = 12'd2726;
    localparam logic [16:0]     ONE_Q16     = 17'd65536;
    localparam logic [SQ_W-1:0] SQ_MAX      = 19'd262144;
    localparam logic [15:0]     HALF_LSB    = 16'd32768;

    typedef enum logic [1:0] {
        REG_STRENGTH     = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // Zero acts as one, anything above the max dimension saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    // |2*pos - size| in half-pixel units.
    function automatic logic [OFS_W-1:0] half_offset(input logic [POS_W-1:0] pos,
                                                     input logic [DIM_W-1:0] size);
        logic [OFS_W:0] a;
        logic [OFS_W:0] b;
        logic [OFS_W:0] d;
        a = {1'b0, pos, 1'b0};
        b = {1'b0, size};
        d = (a >= b) ? (a - b) : (b - a);
        return d[OFS_W-1:0];
    endfunction

    // Channel times Q1.16 gain, rounded, clamped to 255.
    function automatic logic [7:0] scale_chan(input logic [7:0] v,
                                              input logic [GAIN_W-1:0] g);
        logic [25:0] p;
        logic [9:0]  s;
        p = 26'(v) * 26'(g) + 26'(HALF_LSB);
        s = p[25:16];
        return (s > 10'd255) ? 8'd255 : s[7:0];
    endfunction

endpackage

// File: hdl/radial_vignette_pixel_gain_top.sv
// Radial vignette gain pipeline: distance, ratio divider, cosine gain, channel scaling.
// Throughput: one pixel per clock; busy never rises, and the result strobe
// cannot be held off, so the pipeline only advances.
// Depth is set by the 18-stage restoring divider (one quotient bit per stage).
// Reset clears the valid chain and loads strength 0, width 640, height 480.
module radial_vignette_pixel_gain_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] column,
    input  logic [11:0] row,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  red_in,
    output logic        result_valid,
    output logic [7:0]  blue_out,
    output logic [7:0]  green_out,
    output logic [7:0]  red_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int NS = radvig_pkg::DIV_STAGES;

    // ---------------- configuration registers ----------------
    logic [6:0]                   strength_reg;
    logic [radvig_pkg::DIM_W-1:0] width_reg;
    logic [radvig_pkg::DIM_W-1:0] height_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= 7'd0;
            width_reg    <= 13'd640;
            height_reg   <= 13'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                radvig_pkg::REG_STRENGTH:     strength_reg <= cfg_data[6:0];
                radvig_pkg::REG_FRAME_WIDTH:  width_reg    <= cfg_data;
                radvig_pkg::REG_FRAME_HEIGHT: height_reg   <= cfg_data;
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    // Clamped frame size, used directly by the offset stage.
    logic [radvig_pkg::DIM_W-1:0] w_clamp;
    logic [radvig_pkg::DIM_W-1:0] h_clamp;
    assign w_clamp = radvig_pkg::clamp_dim(width_reg);
    assign h_clamp = radvig_pkg::clamp_dim(height_reg);

    // Divisor: (200-strength)^2 * (w^2 + h^2), two register steps behind config.
    // It settles well before any new pixel reaches the divider.
    logic [15:0]                     rad_sq_reg;
    logic [radvig_pkg::OFS_SQ_W-1:0] w_sq_reg;
    logic [radvig_pkg::OFS_SQ_W-1:0] h_sq_reg;
    logic [radvig_pkg::DEN_W-1:0]    den_reg;
    logic [7:0]                      rad;

    assign rad = 8'd200 - {1'b0, strength_reg};

    always_ff @(posedge clk)
    begin
        rad_sq_reg <= rad * rad;
        w_sq_reg   <= w_clamp * w_clamp;
        h_sq_reg   <= h_clamp * h_clamp;
        den_reg    <= radvig_pkg::DEN_W'(rad_sq_reg) *
                      (radvig_pkg::DEN_W'(w_sq_reg) + radvig_pkg::DEN_W'(h_sq_reg));
    end

    // ---------------- front stages: offsets, squares, numerator ----------------
    logic                          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    radvig_pkg::pix_t              s1_pix_reg, s2_pix_reg, s3_pix_reg;
    logic [radvig_pkg::OFS_W-1:0]  dx_reg, dy_reg;
    logic [radvig_pkg::OFS_SQ_W-1:0] dx_sq_reg, dy_sq_reg;
    logic [radvig_pkg::NUM_W-1:0]  num_reg;
    logic                          accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= radvig_pkg::half_offset(column, w_clamp);
        dy_reg     <= radvig_pkg::half_offset(row, h_clamp);
        s1_pix_reg <= '{blue: blue_in, green: green_in, red: red_in};
        dx_sq_reg  <= dx_reg * dx_reg;
        dy_sq_reg  <= dy_reg * dy_reg;
        s2_pix_reg <= s1_pix_reg;
        num_reg    <= (radvig_pkg::NUM_W'(dx_sq_reg) + radvig_pkg::NUM_W'(dy_sq_reg)) *
                      radvig_pkg::NUM_W'(radvig_pkg::RATIO_SCALE);
        s3_pix_reg <= s2_pix_reg;
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    // Stage 1 tests 2*den (integer bit 1) on the numerator, stage 2 tests den
    // (integer bit 0), the rest shift the remainder left and test den for fraction bits.
    logic                         dv_valid_reg [1:NS];
    logic                         dv_sat_reg   [1:NS];
    logic [radvig_pkg::NUM_W-1:0] dv_rem_reg   [1:NS];
    logic [radvig_pkg::Q_W-1:0]   dv_q_reg     [1:NS];
    radvig_pkg::pix_t             dv_pix_reg   [1:NS];

    logic                         dv_sat_next  [1:NS];
    logic [radvig_pkg::NUM_W-1:0] dv_rem_next  [1:NS];
    logic [radvig_pkg::Q_W-1:0]   dv_q_next    [1:NS];

    always_comb
    begin
        logic [radvig_pkg::NUM_W-1:0] trial;
        logic [radvig_pkg::NUM_W-1:0] divisor;
        logic                         qbit;
        // first stage works on the numerator and flags a ratio of two or more
        trial          = num_reg;
        divisor        = {1'b0, den_reg, 1'b0};
        qbit           = (trial >= divisor);
        dv_rem_next[1] = qbit ? (trial - divisor) : trial;
        dv_q_next[1]   = radvig_pkg::Q_W'(qbit);
        dv_sat_next[1] = (num_reg >= {den_reg, 2'b00});
        for (int k = 1; k < NS; k++)
        begin
            if (k >= 2)
                trial = {dv_rem_reg[k][radvig_pkg::NUM_W-2:0], 1'b0};
            else
                trial = dv_rem_reg[k];
            divisor = {2'b00, den_reg};
            qbit = (trial >= divisor);
            dv_rem_next[k+1] = qbit ? (trial - divisor) : trial;
            dv_q_next[k+1]   = {dv_q_reg[k][radvig_pkg::Q_W-2:0], qbit};
            dv_sat_next[k+1] = dv_sat_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NS; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[1] <= s3_valid_reg;
            for (int k = 2; k <= NS; k++)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_pix_reg[1] <= s3_pix_reg;
        for (int k = 1; k <= NS; k++)
        begin
            dv_sat_reg[k] <= dv_sat_next[k];
            dv_rem_reg[k] <= dv_rem_next[k];
            dv_q_reg[k]   <= dv_q_next[k];
        end
        for (int k = 2; k <= NS; k++)
            dv_pix_reg[k] <= dv_pix_reg[k-1];
    end

    // Squared ratio Q3.16, saturated at 4.0.
    logic [radvig_pkg::SQ_W-1:0] sq;
    assign sq = dv_sat_reg[NS] ? radvig_pkg::SQ_MAX : {1'b0, dv_q_reg[NS]};

    // ---------------- gain stages ----------------
    logic                          g1_valid_reg, g2_valid_reg, g3_valid_reg, g4_valid_reg;
    radvig_pkg::pix_t              g1_pix_reg, g2_pix_reg, g3_pix_reg, g4_pix_reg;
    logic [radvig_pkg::SQ_W-1:0]   g1_sq_reg, g2_sq_reg;
    logic [20:0]                   sq2_reg;
    logic [15:0]                   quart_reg;
    logic [radvig_pkg::GAIN_W-1:0] mag_reg;
    logic [radvig_pkg::GAIN_W-1:0] gain_reg;

    logic [38:0] sq2_prod;
    logic [33:0] quart_prod;
    logic [19:0] cos_val;
    logic [34:0] gain_prod;

    always_comb
    begin
        sq2_prod   = 39'(sq) * 39'(sq) + 39'(radvig_pkg::HALF_LSB);
        quart_prod = 34'(radvig_pkg::QUARTIC_Q16) * 34'(sq2_reg) +
                     34'(radvig_pkg::HALF_LSB);
        cos_val    = 20'(radvig_pkg::ONE_Q16) - 20'(g2_sq_reg >> 1) + 20'(quart_reg);
        gain_prod  = 35'(mag_reg) * 35'(mag_reg) + 35'(radvig_pkg::HALF_LSB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            g3_valid_reg <= 1'b0;
            g4_valid_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            g1_valid_reg <= dv_valid_reg[NS];
            g2_valid_reg <= g1_valid_reg;
            g3_valid_reg <= g2_valid_reg;
            g4_valid_reg <= g3_valid_reg;
            result_valid <= g4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // sq^2 in Q5.16
        sq2_reg    <= sq2_prod[36:16];
        g1_sq_reg  <= sq;
        g1_pix_reg <= dv_pix_reg[NS];
        // quartic term
        quart_reg  <= quart_prod[31:16];
        g2_sq_reg  <= g1_sq_reg;
        g2_pix_reg <= g1_pix_reg;
        // cosine magnitude; it can dip below zero near a ratio of two
        mag_reg    <= cos_val[19] ? radvig_pkg::GAIN_W'(-cos_val)
                                  : radvig_pkg::GAIN_W'(cos_val);
        g3_pix_reg <= g2_pix_reg;
        // gain Q1.16
        gain_reg   <= gain_prod[32:16];
        g4_pix_reg <= g3_pix_reg;
        // scale each channel
        blue_out   <= radvig_pkg::scale_chan(g4_pix_reg.blue, gain_reg);
        green_out  <= radvig_pkg::scale_chan(g4_pix_reg.green, gain_reg);
        red_out    <= radvig_pkg::scale_chan(g4_pix_reg.red, gain_reg);
    end

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##26 result_valid)
        else $error("result strobe missing after accepted pixel");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        g4_valid_reg |-> (gain_reg <= radvig_pkg::GAIN_W'(radvig_pkg::ONE_Q16)))
        else $error("gain above unity");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[NS] && !dv_sat_reg[NS]) |-> (dv_rem_reg[NS] < {2'b00, den_reg}))
        else $error("divider remainder not below divisor");

endmodule

// File: tb/sv/radial_vignette_pixel_gain_top_test.sv
// Self-checking testbench for the radial vignette pixel gain block.
`timescale 1ns / 100ps

module radial_vignette_pixel_gain_top_test;

    localparam int LATENCY     = 26;
    localparam int RANDOM_PIX  = 1600;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } bgr_t;

    // One directed row: pixel, and an optional hand-typed result.
    typedef struct {
        logic [11:0] col;
        logic [11:0] rw;
        bgr_t        pix;
        bit          typed;
        bgr_t        want;
    } pixel_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
    logic        result_valid;
    logic [7:0]  blue_out;
    logic [7:0]  green_out;
    logic [7:0]  red_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    // Predictor's copy of the registers.
    logic [6:0]  strength_q;
    logic [12:0] width_q;
    logic [12:0] height_q;

    bgr_t        shaded_pixels[$];
    int          error_count;
    int          cycle_count;
    bit          idle_enabled;

    radial_vignette_pixel_gain_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .column       (column),
        .row          (row),
        .blue_in      (blue_in),
        .green_in     (green_in),
        .red_in       (red_in),
        .result_valid (result_valid),
        .blue_out     (blue_out),
        .green_out    (green_out),
        .red_out      (red_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Effective frame size: zero acts as one, oversize saturates.
    function automatic longint unsigned eff_dim(input logic [12:0] v);
        longint unsigned r;
        if (v == 13'd0)
            r = 1;
        else if (v > 13'(radvig_pkg::MAX_DIM))
            r = longint'(radvig_pkg::MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic longint unsigned offset_sq(input logic [11:0] pos,
                                                  input longint unsigned size);
        longint d;
        d = 2 * longint'(pos) - longint'(size);
        if (d < 0)
            d = -d;
        return d * d;
    endfunction

    // Work out the vignetted pixel from position and source channels.
    function automatic bgr_t vignette_pixel(input logic [11:0] col, input logic [11:0] rw,
                                            input bgr_t src);
        longint unsigned w, h, rad, num, den, q, rem, sq, sq2, quart, m, g, p;
        longint          c;
        bgr_t            res;
        logic [7:0]      ch[3];
        w   = eff_dim(width_q);
        h   = eff_dim(height_q);
        rad = 200 - strength_q;
        num = (offset_sq(col, w) + offset_sq(rw, h)) * 40000;
        den = rad * rad * (w * w + h * h);
        // Saturate the squared ratio at 4.0.
        if (num >= 4 * den)
            sq = 4 * 65536;
        else
        begin
            q   = num / den;
            rem = num % den;
            for (int i = 0; i < 16; i++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    q   = q | 1;
                end
            end
            sq = q;
        end
        sq2   = (sq * sq + 32768) >> 16;
        quart = (2726 * sq2 + 32768) >> 16;
        c     = 65536 - longint'(sq >> 1) + longint'(quart);
        m     = (c < 0) ? -c : c;
        g     = (m * m + 32768) >> 16;
        ch[0] = src.blue;
        ch[1] = src.green;
        ch[2] = src.red;
        for (int k = 0; k < 3; k++)
        begin
            p = (ch[k] * g + 32768) >> 16;
            ch[k] = (p > 255) ? 8'd255 : p[7:0];
        end
        res.blue  = ch[0];
        res.green = ch[1];
        res.red   = ch[2];
        return res;
    endfunction

    // Send one config beat and mirror it in the predictor.
    task automatic write_reg(input radvig_pkg::cfg_index_t idx, input logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            radvig_pkg::REG_STRENGTH:     strength_q = val[6:0];
            radvig_pkg::REG_FRAME_WIDTH:  width_q    = val;
            radvig_pkg::REG_FRAME_HEIGHT: height_q   = val;
            default:                      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drive one pixel beat; the expected result is queued when it is taken.
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] rw,
                              input bgr_t src, input bit typed, input bgr_t want);
        bgr_t predicted;
        start    <= 1'b1;
        column   <= col;
        row      <= rw;
        blue_in  <= src.blue;
        green_in <= src.green;
        red_in   <= src.red;
        do
            @(posedge clk);
        while (busy);
        predicted = vignette_pixel(col, rw, src);
        if (typed && predicted != want)
        begin
            $display("%0t directed row predictor mismatch: expected %h actual %h",
                     $time, want, predicted);
            error_count++;
        end
        shaded_pixels.push_back(typed ? want : predicted);
        @(negedge clk);
        // Drop start only if an idle burst follows; otherwise the next beat keeps it high.
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Let the pipeline empty before touching registers.
    task automatic drain();
        start <= 1'b0;
        while (shaded_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic bgr_t rand_bgr();
        bgr_t v;
        v = 24'($urandom);
        // Lean on the extremes of the blue channel and on full red.
        if ($urandom_range(0, 7) == 0)
            v.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            v.red = 8'hFF;
        return v;
    endfunction

    // Check each result beat against the oldest expected pixel.
    always @(posedge clk)
    begin
        bgr_t exp_pix;
        if (rst_n && result_valid)
        begin
            if (shaded_pixels.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h %h %h",
                         $time, blue_out, green_out, red_out);
                error_count++;
            end
            else
            begin
                exp_pix = shaded_pixels.pop_front();
                if (blue_out !== exp_pix.blue)
                begin
                    $display("%0t blue_out: expected %h actual %h", $time, exp_pix.blue,
                             blue_out);
                    error_count++;
                end
                if (green_out !== exp_pix.green)
                begin
                    $display("%0t green_out: expected %h actual %h", $time, exp_pix.green,
                             green_out);
                    error_count++;
                end
                if (red_out !== exp_pix.red)
                begin
                    $display("%0t red_out: expected %h actual %h", $time, exp_pix.red,
                             red_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("radial_vignette_pixel_gain_top_test: errors");
            $finish;
        end
    end

    initial
    begin
        pixel_row_t  directed[$];
        pixel_row_t  r;
        logic [12:0] w_set[6];
        logic [12:0] h_set[6];
        logic [6:0]  s_set[6];
        logic [12:0] w_eff;
        logic [12:0] h_eff;
        int          per_phase;

        error_count  = 0;
        cycle_count  = 0;
        idle_enabled = 1'b1;
        rst_n     = 1'b0;
        start     = 1'b0;
        column    = '0;
        row       = '0;
        blue_in   = '0;
        green_in  = '0;
        red_in    = '0;
        cfg_valid = 1'b0;
        cfg_index = radvig_pkg::REG_STRENGTH;
        cfg_data  = '0;
        strength_q = 7'd0;
        width_q    = 13'd640;
        height_q   = 13'd480;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows at reset settings. Centre pixel has gain exactly one.
        r.typed = 1'b1;
        r.col = 12'd320; r.rw = 12'd240;
        r.pix = '{8'hFF, 8'h80, 8'h00}; r.want = '{8'hFF, 8'h80, 8'h00};
        directed.push_back(r);
        r.pix = '{8'h00, 8'h00, 8'h00}; r.want = '{8'h00, 8'h00, 8'h00};
        directed.push_back(r);
        r.typed = 1'b0;
        r.col = 12'd0;    r.rw = 12'd0;    r.pix = '{8'hFF, 8'hFF, 8'hFF};
        directed.push_back(r);
        r.col = 12'd639;  r.rw = 12'd479;  r.pix = '{8'h01, 8'h7F, 8'hFE};
        directed.push_back(r);
        // Pixels outside the frame saturate the ratio.
        r.col = 12'd4095; r.rw = 12'd4095; r.pix = '{8'hFF, 8'hAA, 8'h55};
        directed.push_back(r);
        r.col = 12'd4095; r.rw = 12'd0;    r.pix = '{8'h55, 8'hFF, 8'hAA};
        directed.push_back(r);
        r.col = 12'd0;    r.rw = 12'd4095; r.pix = '{8'hAA, 8'h55, 8'hFF};
        directed.push_back(r);
        r.col = 12'd320;  r.rw = 12'd0;    r.pix = '{8'hFF, 8'hFF, 8'hFF};
        directed.push_back(r);
        r.col = 12'd0;    r.rw = 12'd240;  r.pix = '{8'hFF, 8'hFF, 8'hFF};
        directed.push_back(r);
        r.col = 12'hAAA;  r.rw = 12'h555;  r.pix = '{8'hFF, 8'hFF, 8'hFF};
        directed.push_back(r);
        foreach (directed[i])
            send_pixel(directed[i].col, directed[i].rw, directed[i].pix,
                       directed[i].typed, directed[i].want);
        drain();

        // Special register settings: zero size, oversize, strength past 100.
        write_reg(radvig_pkg::REG_FRAME_WIDTH, 13'd0);
        write_reg(radvig_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        write_reg(radvig_pkg::REG_STRENGTH, 7'd127);
        r.typed = 1'b0;
        send_pixel(12'd0, 12'd2048, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, r.want);
        send_pixel(12'd1, 12'd0, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, r.want);
        send_pixel(12'd4095, 12'd4095, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, r.want);
        drain();
        write_reg(radvig_pkg::REG_FRAME_WIDTH, 13'd4096);
        write_reg(radvig_pkg::REG_FRAME_HEIGHT, 13'd1);
        write_reg(radvig_pkg::REG_STRENGTH, 7'd100);
        send_pixel(12'd2048, 12'd0, '{8'hFF, 8'h80, 8'h01}, 1'b0, r.want);
        send_pixel(12'd0, 12'd0, '{8'hFF, 8'h80, 8'h01}, 1'b0, r.want);
        send_pixel(12'd4095, 12'd1, '{8'hFF, 8'h80, 8'h01}, 1'b0, r.want);
        drain();

        // Random phases across several register settings.
        w_set = '{13'd640, 13'd1, 13'd4096, 13'd16, 13'h1FFF, 13'd1920};
        h_set = '{13'd480, 13'd4096, 13'd1, 13'd0, 13'd1080, 13'd33};
        s_set = '{7'd0, 7'd100, 7'd50, 7'd127, 7'd1, 7'd73};
        per_phase = RANDOM_PIX / 8;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 6)
            begin
                write_reg(radvig_pkg::REG_FRAME_WIDTH, w_set[ph]);
                write_reg(radvig_pkg::REG_FRAME_HEIGHT, h_set[ph]);
                write_reg(radvig_pkg::REG_STRENGTH, s_set[ph]);
            end
            else
            begin
                write_reg(radvig_pkg::REG_FRAME_WIDTH, 13'($urandom_range(0, 8191)));
                write_reg(radvig_pkg::REG_FRAME_HEIGHT, 13'($urandom_range(0, 8191)));
                write_reg(radvig_pkg::REG_STRENGTH, 7'($urandom_range(0, 127)));
            end
            // No idling in the closing phase.
            idle_enabled = (ph != 7);
            w_eff = 13'(eff_dim(width_q));
            h_eff = 13'(eff_dim(height_q));
            for (int n = 0; n < per_phase; n++)
            begin
                logic [11:0] cx;
                logic [11:0] cy;
                // Mostly in-frame pixels, some anywhere.
                if ($urandom_range(0, 4) != 0)
                begin
                    cx = 12'($urandom_range(0, int'(w_eff) - 1));
                    cy = 12'($urandom_range(0, int'(h_eff) - 1));
                end
                else
                begin
                    cx = 12'($urandom);
                    cy = 12'($urandom);
                end
                send_pixel(cx, cy, rand_bgr(), 1'b0, r.want);
            end
            drain();
        end

        repeat (LATENCY + 8) @(negedge clk);
        if (error_count == 0 && shaded_pixels.size() == 0)
            $display("radial_vignette_pixel_gain_top_test: clean");
        else
            $display("radial_vignette_pixel_gain_top_test: errors");
        $finish;
    end

endmodule
